// ----- rtl/core/alsd_pkg.sv -----
package alsd_pkg;

    localparam int MAX_LEDS = 256;
    localparam int PIX_AW   = $clog2(MAX_LEDS);
    localparam int CNT_W    = PIX_AW + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_TICK = 2'd0;
    localparam t_kind KIND_RGB  = 2'd1;
    localparam t_kind KIND_HSV  = 2'd2;
    localparam t_kind KIND_SHOW = 2'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LED_COUNT = 3'd0;
    localparam t_cfg_idx CFG_ZERO_HIGH = 3'd1;
    localparam t_cfg_idx CFG_ZERO_LOW  = 3'd2;
    localparam t_cfg_idx CFG_ONE_HIGH  = 3'd3;
    localparam t_cfg_idx CFG_ONE_LOW   = 3'd4;
    localparam t_cfg_idx CFG_LATCH_LOW = 3'd5;

    // reciprocal multipliers, exact over the value ranges used
    localparam logic [31:0] HUE_RECIP = 32'd46604;  // 2^24 / 360
    localparam logic [28:0] PCT_RECIP = 29'd10486;  // 2^20 / 100
    localparam logic [19:0] SEC_RECIP = 20'd1093;   // 2^16 / 60
    localparam logic [28:0] DEG_RECIP = 29'd17477;  // 2^20 / 60

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  start_index;
        logic [8:0]  fill_count;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] hue;
        logic [6:0]  saturation;
        logic [6:0]  brightness;
    } t_item;

    typedef struct packed {
        logic line_level;
        logic sending;
        logic frame_done;
        logic rejected;
    } t_result;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  start_index;
        logic [8:0]  fill_count;
        logic [23:0] grb;
    } t_cmd;

    typedef struct packed {
        logic [8:0]  led_count;
        logic [7:0]  zero_high_ticks;
        logic [7:0]  zero_low_ticks;
        logic [7:0]  one_high_ticks;
        logic [7:0]  one_low_ticks;
        logic [15:0] latch_low_ticks;
    } t_cfg;

endpackage

// ----- rtl/core/alsd_ram.sv -----
module alsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/core/alsd_hsv.sv -----
module alsd_hsv import alsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_hue,
    input  logic [6:0]  i_sat,
    input  logic [6:0]  i_val,
    output logic        o_done,
    output logic [23:0] o_grb
);

    localparam logic [2:0] LAST_STEP = 3'd6;

    logic        r_run;
    logic [2:0]  r_step;
    logic        r_done;
    logic [15:0] r_hue;
    logic [6:0]  r_s;
    logic [6:0]  r_v;
    logic [7:0]  r_hq;
    logic [14:0] r_v255;
    logic [8:0]  r_h;
    logic [7:0]  r_mx;
    logic [14:0] r_t;
    logic [2:0]  r_sec;
    logic [7:0]  r_mn;
    logic [5:0]  r_hm;
    logic [13:0] r_d;
    logic [7:0]  r_adj;
    logic [23:0] r_grb;

    logic [31:0] w_hq;
    logic [28:0] w_mx;
    logic [19:0] w_sec;
    logic [28:0] w_mn;
    logic [28:0] w_adj;
    logic [7:0]  w_up;
    logic [7:0]  w_down;
    logic [23:0] w_grb;

    always_comb begin
        w_hq   = 32'(r_hue) * HUE_RECIP;
        w_mx   = 29'(r_v255) * PCT_RECIP;
        w_sec  = 20'(r_h) * SEC_RECIP;
        w_mn   = 29'(r_t) * PCT_RECIP;
        w_adj  = 29'(r_d) * DEG_RECIP;
        w_up   = r_mn + r_adj;
        w_down = r_mx - r_adj;
        // packed as green, red, blue
        unique case (r_sec)
            3'd0:    w_grb = {w_up,   r_mx,   r_mn};
            3'd1:    w_grb = {r_mx,   w_down, r_mn};
            3'd2:    w_grb = {r_mx,   r_mn,   w_up};
            3'd3:    w_grb = {w_down, r_mn,   r_mx};
            3'd4:    w_grb = {r_mn,   w_up,   r_mx};
            default: w_grb = {r_mn,   r_mx,   w_down};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + 3'd1;
                if (r_step == LAST_STEP) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hue <= i_hue;
            r_s   <= (i_sat > 7'd100) ? 7'd100 : i_sat;
            r_v   <= (i_val > 7'd100) ? 7'd100 : i_val;
        end else if (r_run) begin
            unique case (r_step)
                3'd0: begin
                    r_hq   <= w_hq[31:24];
                    r_v255 <= 15'(r_v) * 15'd255;
                end
                3'd1: begin
                    r_h  <= 9'(r_hue - 16'(r_hq) * 16'd360);
                    r_mx <= w_mx[27:20];
                end
                3'd2: begin
                    r_t   <= 15'(r_mx) * 15'(7'd100 - r_s);
                    r_sec <= w_sec[18:16];
                end
                3'd3: begin
                    r_mn <= w_mn[27:20];
                    r_hm <= 6'(r_h - 9'(r_sec) * 9'd60);
                end
                3'd4: begin
                    r_d <= 14'(r_mx - r_mn) * 14'(r_hm);
                end
                3'd5: begin
                    r_adj <= w_adj[27:20];
                end
                default: begin
                    r_grb <= w_grb;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_grb  = r_grb;

endmodule

// ----- rtl/core/alsd_front.sv -----
module alsd_front import alsd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_cmd_full,
    output logic  o_cmd_push,
    output t_cmd  o_cmd
);

    logic        r_hold;
    logic        r_ready;
    t_item       r_item;
    logic [23:0] r_grb;

    logic        w_accept;
    logic        w_hsv_done;
    logic [23:0] w_hsv_grb;

    assign w_accept   = i_push && !r_hold;
    assign o_full     = r_hold;
    assign o_cmd_push = r_hold && r_ready && !i_cmd_full;

    alsd_hsv u_hsv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && (i_item.kind == KIND_HSV)),
        .i_hue   (i_item.hue),
        .i_sat   (i_item.saturation),
        .i_val   (i_item.brightness),
        .o_done  (w_hsv_done),
        .o_grb   (w_hsv_grb)
    );

    always_comb begin
        o_cmd.kind        = r_item.kind;
        o_cmd.start_index = r_item.start_index;
        o_cmd.fill_count  = r_item.fill_count;
        o_cmd.grb         = r_grb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= 1'b0;
            r_ready <= 1'b0;
        end else begin
            priority if (w_accept) begin
                r_hold  <= 1'b1;
                r_ready <= (i_item.kind != KIND_HSV);
            end else if (o_cmd_push) begin
                r_hold  <= 1'b0;
                r_ready <= 1'b0;
            end else if (w_hsv_done) begin
                r_ready <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
            r_grb  <= {i_item.green, i_item.red, i_item.blue};
        end else if (w_hsv_done) begin
            r_grb <= w_hsv_grb;
        end
    end

endmodule

// ----- rtl/core/alsd_back.sv -----
module alsd_back import alsd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_cmd_push,
    input  t_cmd    i_cmd,
    output logic    o_cmd_full,
    input  logic    i_res_pop,
    output logic    o_res_empty,
    output t_result o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FILL = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_TICK = 2'd3;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_BITS  = 2'd1;
    localparam logic [1:0] PH_LATCH = 2'd2;

    // command queue
    t_cmd       r_cq [2];
    logic       r_cwp;
    logic       r_crp;
    logic [1:0] r_ccnt;
    // result queue
    t_result    r_rq [2];
    logic       r_rwp;
    logic       r_rrp;
    logic [1:0] r_rcnt;

    logic [1:0]          r_state, n_state;
    logic [1:0]          r_phase, n_phase;
    logic [PIX_AW-1:0]   r_px, n_px;
    logic [4:0]          r_bit, n_bit;
    logic                r_half, n_half;
    logic [15:0]         r_tc, n_tc;
    logic                r_pix_ok, n_pix_ok;
    logic [23:0]         r_pix, n_pix;
    logic                r_rd_vld;
    logic [CNT_W-1:0]    r_fp, n_fp;
    logic [8:0]          r_left, n_left;
    logic [23:0]         r_fill_grb, n_fill_grb;
    logic [MAX_LEDS-1:0] r_valid;

    t_cmd             w_cmd;
    logic             w_cmd_pop;
    logic             w_res_push;
    logic             w_res_pop;
    t_result          w_res;
    logic             w_we;
    logic [23:0]      w_rdata;
    logic [CNT_W-1:0] w_eff;
    logic             w_busy;
    logic             w_one;
    logic [7:0]       w_dur8;
    logic [7:0]       w_dur;
    logic [15:0]      w_ldur;
    logic [15:0]      w_tc_inc;
    logic [CNT_W-1:0] w_px_inc;

    alsd_ram #(
        .WIDTH (24),
        .DEPTH (MAX_LEDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fp[PIX_AW-1:0]),
        .i_wdata (r_fill_grb),
        .i_raddr (r_px),
        .o_rdata (w_rdata)
    );

    assign o_cmd_full  = (r_ccnt == 2'd2);
    assign o_res_empty = (r_rcnt == 2'd0);
    assign o_res       = r_rq[r_rrp];
    assign w_cmd       = r_cq[r_crp];
    assign w_res_pop   = i_res_pop && (r_rcnt != 2'd0);

    always_comb begin
        if (int'(i_cfg.led_count) < 2) begin
            w_eff = CNT_W'(2);
        end else if (int'(i_cfg.led_count) > MAX_LEDS) begin
            w_eff = CNT_W'(MAX_LEDS);
        end else begin
            w_eff = CNT_W'(i_cfg.led_count);
        end
        w_busy   = (r_phase != PH_IDLE);
        w_one    = r_pix[5'd23 - r_bit];
        if (!r_half) begin
            w_dur8 = w_one ? i_cfg.one_high_ticks : i_cfg.zero_high_ticks;
        end else begin
            w_dur8 = w_one ? i_cfg.one_low_ticks : i_cfg.zero_low_ticks;
        end
        w_dur    = (w_dur8 == 8'd0) ? 8'd1 : w_dur8;
        w_ldur   = (i_cfg.latch_low_ticks == 16'd0) ? 16'd1 : i_cfg.latch_low_ticks;
        w_tc_inc = r_tc + 16'd1;
        w_px_inc = CNT_W'(r_px) + CNT_W'(1);
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_px       = r_px;
        n_bit      = r_bit;
        n_half     = r_half;
        n_tc       = r_tc;
        n_pix_ok   = r_pix_ok;
        n_pix      = r_pix;
        n_fp       = r_fp;
        n_left     = r_left;
        n_fill_grb = r_fill_grb;
        w_cmd_pop  = 1'b0;
        w_res_push = 1'b0;
        w_res      = '0;
        w_we       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if ((r_ccnt != 2'd0) && (r_rcnt != 2'd2)) begin
                    w_cmd_pop = 1'b1;
                    unique case (w_cmd.kind)
                        KIND_TICK: begin
                            priority if (r_phase == PH_BITS) begin
                                n_state = r_pix_ok ? S_TICK : S_WAIT;
                            end else if (r_phase == PH_LATCH) begin
                                w_res_push    = 1'b1;
                                w_res.sending = 1'b1;
                                if (w_tc_inc >= w_ldur) begin
                                    n_tc             = '0;
                                    n_phase          = PH_IDLE;
                                    w_res.frame_done = 1'b1;
                                end else begin
                                    n_tc = w_tc_inc;
                                end
                            end else begin
                                w_res_push = 1'b1;
                            end
                        end
                        KIND_RGB, KIND_HSV: begin
                            w_res_push = 1'b1;
                            if (w_busy) begin
                                w_res.rejected   = 1'b1;
                                w_res.sending    = 1'b1;
                                w_res.line_level = (r_phase == PH_BITS) && !r_half;
                            end else begin
                                n_fp       = CNT_W'(w_cmd.start_index);
                                n_left     = w_cmd.fill_count;
                                n_fill_grb = w_cmd.grb;
                                n_state    = S_FILL;
                            end
                        end
                        default: begin
                            w_res_push    = 1'b1;
                            w_res.sending = 1'b1;
                            if (w_busy) begin
                                w_res.rejected   = 1'b1;
                                w_res.line_level = (r_phase == PH_BITS) && !r_half;
                            end else begin
                                n_phase  = PH_BITS;
                                n_px     = '0;
                                n_bit    = '0;
                                n_half   = 1'b0;
                                n_tc     = '0;
                                n_pix_ok = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_FILL: begin
                if ((r_left != 9'd0) && (r_fp < w_eff)) begin
                    w_we   = 1'b1;
                    n_fp   = r_fp + CNT_W'(1);
                    n_left = r_left - 9'd1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WAIT: begin
                n_pix    = r_rd_vld ? w_rdata : 24'd0;
                n_pix_ok = 1'b1;
                n_state  = S_TICK;
            end
            default: begin
                w_res_push       = 1'b1;
                w_res.sending    = 1'b1;
                w_res.line_level = !r_half;
                n_state          = S_IDLE;
                if (w_tc_inc >= 16'(w_dur)) begin
                    n_tc = '0;
                    if (!r_half) begin
                        n_half = 1'b1;
                    end else begin
                        n_half = 1'b0;
                        // strip may have been shortened while the frame runs
                        if (((r_bit == 5'd23) && (w_px_inc >= w_eff)) ||
                            (CNT_W'(r_px) >= w_eff)) begin
                            n_bit    = '0;
                            n_pix_ok = 1'b0;
                            n_phase  = PH_LATCH;
                            n_px     = '0;
                        end else if (r_bit == 5'd23) begin
                            n_bit    = '0;
                            n_pix_ok = 1'b0;
                            n_px     = w_px_inc[PIX_AW-1:0];
                        end else begin
                            n_bit = r_bit + 5'd1;
                        end
                    end
                end else begin
                    n_tc = w_tc_inc;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_IDLE;
            r_px     <= '0;
            r_bit    <= '0;
            r_half   <= 1'b0;
            r_tc     <= '0;
            r_pix_ok <= 1'b0;
            r_fp     <= '0;
            r_left   <= '0;
            r_valid  <= '0;
            r_cwp    <= 1'b0;
            r_crp    <= 1'b0;
            r_ccnt   <= '0;
            r_rwp    <= 1'b0;
            r_rrp    <= 1'b0;
            r_rcnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_px     <= n_px;
            r_bit    <= n_bit;
            r_half   <= n_half;
            r_tc     <= n_tc;
            r_pix_ok <= n_pix_ok;
            r_fp     <= n_fp;
            r_left   <= n_left;
            if (w_we) begin
                r_valid[r_fp[PIX_AW-1:0]] <= 1'b1;
            end
            if (i_cmd_push) begin
                r_cwp <= ~r_cwp;
            end
            if (w_cmd_pop) begin
                r_crp <= ~r_crp;
            end
            r_ccnt <= r_ccnt + 2'(i_cmd_push) - 2'(w_cmd_pop);
            if (w_res_push) begin
                r_rwp <= ~r_rwp;
            end
            if (w_res_pop) begin
                r_rrp <= ~r_rrp;
            end
            r_rcnt <= r_rcnt + 2'(w_res_push) - 2'(w_res_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix      <= n_pix;
        r_fill_grb <= n_fill_grb;
        r_rd_vld   <= r_valid[r_px];
        if (i_cmd_push) begin
            r_cq[r_cwp] <= i_cmd;
        end
        if (w_res_push) begin
            r_rq[r_rwp] <= w_res;
        end
    end

`ifndef ASSERT_OFF
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> (r_rcnt != 2'd2))
        else $error("result queue overflow");

    a_cmd_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_push |-> (r_ccnt != 2'd2))
        else $error("command queue overflow");

    a_fill_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_fp < w_eff) && (r_phase == PH_IDLE))
        else $error("pixel write outside strip or during frame");

    a_done_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_push && w_res.frame_done) |-> (r_phase == PH_LATCH) && w_res.sending)
        else $error("frame end outside latch gap");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_push && w_res.rejected) |-> (r_phase != PH_IDLE))
        else $error("request dropped while idle");
`endif

endmodule

// ----- rtl/core/addressable_led_strip_driver_unit.sv -----
// channel   dir  handshake                    payload
// item      in   push / full                  i_item (t_item)
// result    out  pop / empty                  o_result (t_result)
// config    in   i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// front holds one request; it takes the next one the cycle after handing it to
// the two-entry command queue, so it cannot take a new request while it holds one
// hsv fill first passes through the stepped hsv converter, which the front waits on
// tick: idle then tick state in the back, with a wait state between for a new pixel ram word
// fill: the back writes one pixel at a time in the fill state (one ram write port)
// reset is synchronous, active low; per-pixel valid bits make the store read zero
// a full result queue stalls the back, a full command queue stalls the front
module addressable_led_strip_driver_unit import alsd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  t_item                 i_item,
    output logic                  full,
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic w_cmd_push;
    logic w_cmd_full;
    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_count       <= 9'd100;
            r_cfg.zero_high_ticks <= 8'd3;
            r_cfg.zero_low_ticks  <= 8'd9;
            r_cfg.one_high_ticks  <= 8'd9;
            r_cfg.one_low_ticks   <= 8'd3;
            r_cfg.latch_low_ticks <= 16'd500;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LED_COUNT: r_cfg.led_count       <= i_cfg_data[8:0];
                CFG_ZERO_HIGH: r_cfg.zero_high_ticks <= i_cfg_data[7:0];
                CFG_ZERO_LOW:  r_cfg.zero_low_ticks  <= i_cfg_data[7:0];
                CFG_ONE_HIGH:  r_cfg.one_high_ticks  <= i_cfg_data[7:0];
                CFG_ONE_LOW:   r_cfg.one_low_ticks   <= i_cfg_data[7:0];
                CFG_LATCH_LOW: r_cfg.latch_low_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    alsd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .i_cmd_full (w_cmd_full),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd)
    );

    alsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_push  (w_cmd_push),
        .i_cmd       (w_cmd),
        .o_cmd_full  (w_cmd_full),
        .i_res_pop   (pop),
        .o_res_empty (empty),
        .o_res       (o_result)
    );

endmodule
